@@ rtl/core/aef_pkg.sv @@
`timescale 1ns / 1ps

package aef_pkg;

  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_ADDR_W-1:0] REG_FILTER_MODE = 2'd0;

  localparam logic MODE_KEEP_TEXT   = 1'b0;
  localparam logic MODE_KEEP_ESCAPE = 1'b1;

  localparam logic [7:0] BYTE_ESC = 8'h1B;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } aef_beat_t;

endpackage

@@ rtl/core/ansi_escape_filter_unit.sv @@
`timescale 1ns / 1ps

// Byte stream filter for terminal traffic carrying ANSI/DEC escape sequences.
// in_*  : one raw byte per item on in_tdata.
// out_* : bytes passed on by the filter; dropped bytes produce no item.
// cfg_* : APB register port, register filter_mode at address 0 (bit 0):
//         0 keeps plain text, 1 keeps escape sequences (ESC and every byte
//         inside a sequence). Write only while no item is in flight.
// An item passes through an input hold register and the output register,
// so a kept byte appears on out_tvalid from the output register, not combinationally.
// One item per cycle is taken and delivered while out_tready does not stall; the single parser state register
// is updated in the same cycle as the hold register drains.
// A stall on out_tready holds the output register and, through it, the
// hold register; in_tready falls once both are occupied and rises again
// in the cycle the stall clears.
// Reset (rst_n low, synchronous) empties both registers, returns the parser
// to idle and sets filter_mode to keep text.
module ansi_escape_filter_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,   // [7:0] data_byte
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [7:0]                     out_tdata,  // [7:0] out_byte
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [aef_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [aef_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [aef_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready
);
  import aef_pkg::*;

  logic      filter_mode;
  logic      out_space;
  aef_beat_t beat;
  logic      out_valid_r;
  logic      out_valid_nxt;
  logic [7:0] out_data_r;

  aef_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .filter_mode (filter_mode)
  );

  aef_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_byte     (in_tdata),
    .in_ready    (in_tready),
    .filter_mode (filter_mode),
    .out_space   (out_space),
    .beat        (beat)
  );

  assign out_space     = !out_valid_r || out_tready;
  assign out_valid_nxt = out_space ? beat.valid : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (beat.valid) begin
      out_data_r <= beat.data;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTHESIS
  a_text_mode_drops_esc: assert property (@(posedge clk) disable iff (!rst_n)
    (beat.valid && filter_mode == MODE_KEEP_TEXT) |=> (out_tdata != BYTE_ESC))
    else $error("escape byte passed in keep-text mode");

  a_no_load_while_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |-> !beat.valid)
    else $error("result produced while output register is stalled");

  a_load_shows_valid: assert property (@(posedge clk) disable iff (!rst_n)
    beat.valid |=> out_tvalid)
    else $error("produced result not presented");
`endif

endmodule

@@ rtl/core/aef_cfg.sv @@
`timescale 1ns / 1ps

module aef_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [aef_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [aef_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [aef_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready,
  output logic                           filter_mode
);
  import aef_pkg::*;

  logic mode_r;
  logic mode_nxt;
  logic wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    mode_nxt = mode_r;
    if (wr_en && (cfg_paddr == REG_FILTER_MODE)) begin
      mode_nxt = cfg_pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_KEEP_TEXT;
    end else begin
      mode_r <= mode_nxt;
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr == REG_FILTER_MODE) begin
      cfg_prdata = {{(CFG_DATA_W-1){1'b0}}, mode_r};
    end
  end

  assign filter_mode = mode_r;

endmodule

@@ rtl/core/aef_parser.sv @@
`timescale 1ns / 1ps

module aef_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [7:0]        in_byte,
  output logic              in_ready,
  input  logic              filter_mode,
  input  logic              out_space,
  output aef_pkg::aef_beat_t beat
);
  import aef_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE     = 8'b0000_0001,
    ST_ESC      = 8'b0000_0010,
    ST_STR      = 8'b0000_0100,
    ST_LSTR     = 8'b0000_1000,
    ST_ESC_STR  = 8'b0001_0000,
    ST_ESC_LSTR = 8'b0010_0000,
    ST_CSI      = 8'b0100_0000,
    ST_IB       = 8'b1000_0000
  } parser_state_t;

  logic          hold_valid_r;
  logic          hold_valid_nxt;
  logic [7:0]    hold_byte_r;
  parser_state_t state_r;
  parser_state_t state_nxt;
  parser_state_t step_state;
  logic          advance;
  logic          emit;

  assign advance  = hold_valid_r && out_space;
  assign in_ready = !hold_valid_r || out_space;

  always_comb begin
    case (state_r)
      ST_IDLE: begin
        step_state = (hold_byte_r == BYTE_ESC) ? ST_ESC : ST_IDLE;
      end
      ST_ESC: begin
        case (hold_byte_r) inside
          "X":                step_state = ST_STR;
          "P", "]", "^", "_": step_state = ST_LSTR;
          "[":                step_state = ST_CSI;
          default:            step_state = ST_IDLE;
        endcase
      end
      ST_LSTR: begin
        if (hold_byte_r == BYTE_ESC) begin
          step_state = ST_ESC_STR;
        end else if (hold_byte_r inside {[8'h00:8'h07], [8'h0E:8'h1F], [8'h7F:8'hFF]}) begin
          step_state = ST_IDLE;
        end else begin
          step_state = ST_LSTR;
        end
      end
      ST_ESC_LSTR: begin
        step_state = ST_IDLE;
      end
      ST_ESC_STR: begin
        step_state = (hold_byte_r == "X" || hold_byte_r == "\\") ? ST_IDLE : ST_ESC_STR;
      end
      ST_STR: begin
        step_state = (hold_byte_r == BYTE_ESC) ? ST_ESC_STR : ST_STR;
      end
      ST_CSI: begin
        case (hold_byte_r) inside
          ["@":"~"]: step_state = ST_IDLE;
          [" ":"/"]: step_state = ST_IB;
          ["0":"?"]: step_state = ST_CSI;
          default:   step_state = ST_IDLE;
        endcase
      end
      ST_IB: begin
        step_state = ST_IDLE;
      end
      default: begin
        step_state = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (filter_mode == MODE_KEEP_TEXT) begin
      emit = (state_r == ST_IDLE) && (hold_byte_r != BYTE_ESC);
    end else begin
      emit = (state_r != ST_IDLE) || (hold_byte_r == BYTE_ESC);
    end
  end

  assign state_nxt      = advance ? step_state : state_r;
  assign hold_valid_nxt = in_ready ? in_valid : hold_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
      state_r      <= ST_IDLE;
    end else begin
      hold_valid_r <= hold_valid_nxt;
      state_r      <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      hold_byte_r <= in_byte;
    end
  end

  assign beat.valid = advance && emit;
  assign beat.data  = hold_byte_r;

`ifndef SYNTHESIS
  a_lstr_esc_unreached: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_ESC_LSTR)
    else $error("escape-in-limited-string state reached");

  a_ib_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && state_r == ST_IB) |=> (state_r == ST_IDLE))
    else $error("intermediate state did not return to idle");

  a_state_holds_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> (state_r == $past(state_r)))
    else $error("parser state moved without an item");
`endif

endmodule

@@ tb/sv/ansi_escape_filter_unit_tb.sv @@
`timescale 1ns / 1ps

module ansi_escape_filter_unit_tb;
  import aef_pkg::*;

  typedef enum logic [2:0] {
    PS_IDLE     = 3'd0,
    PS_ESC      = 3'd1,
    PS_STR      = 3'd2,
    PS_LSTR     = 3'd3,
    PS_ESC_STR  = 3'd4,
    PS_ESC_LSTR = 3'd5,
    PS_CSI      = 3'd6,
    PS_INTER    = 3'd7
  } parse_state_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] data;
    logic       fixed;
    logic       kept;
    logic [7:0] kept_byte;
  } stim_row_t;

  localparam logic [7:0] CH_X     = 8'h58;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_LBR   = 8'h5B;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_RBR   = 8'h5D;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_USC   = 8'h5F;

  localparam int unsigned ROW_COUNT = 25;

  localparam stim_row_t DIRECTED_ROWS [ROW_COUNT] = '{
    '{MODE_KEEP_TEXT,   8'h00,    1'b1, 1'b1, 8'h00},
    '{MODE_KEEP_TEXT,   8'hFF,    1'b1, 1'b1, 8'hFF},
    '{MODE_KEEP_TEXT,   BYTE_ESC, 1'b1, 1'b0, 8'h00},
    '{MODE_KEEP_TEXT,   CH_LBR,   1'b0, 1'b0, 8'h00},
    '{MODE_KEEP_TEXT,   8'h31,    1'b0, 1'b0, 8'h00},
    '{MODE_KEEP_TEXT,   8'h20,    1'b0, 1'b0, 8'h00},
    '{MODE_KEEP_TEXT,   8'h41,    1'b0, 1'b0, 8'h00},
    '{MODE_KEEP_TEXT,   8'h41,    1'b1, 1'b1, 8'h41},
    '{MODE_KEEP_ESCAPE, 8'h7A,    1'b1, 1'b0, 8'h00},
    '{MODE_KEEP_ESCAPE, BYTE_ESC, 1'b1, 1'b1, BYTE_ESC},
    '{MODE_KEEP_ESCAPE, CH_X,     1'b0, 1'b0, 8'h00},
    '{MODE_KEEP_ESCAPE, BYTE_ESC, 1'b0, 1'b0, 8'h00},
    '{MODE_KEEP_ESCAPE, BYTE_ESC, 1'b0, 1'b0, 8'h00},
    '{MODE_KEEP_ESCAPE, 8'h61,    1'b0, 1'b0, 8'h00},
    '{MODE_KEEP_ESCAPE, CH_BSL,   1'b0, 1'b0, 8'h00},
    '{MODE_KEEP_ESCAPE, BYTE_ESC, 1'b0, 1'b0, 8'h00},
    '{MODE_KEEP_ESCAPE, CH_RBR,   1'b0, 1'b0, 8'h00},
    '{MODE_KEEP_ESCAPE, 8'h0D,    1'b0, 1'b0, 8'h00},
    '{MODE_KEEP_ESCAPE, 8'h80,    1'b0, 1'b0, 8'h00},
    '{MODE_KEEP_ESCAPE, BYTE_ESC, 1'b0, 1'b0, 8'h00},
    '{MODE_KEEP_ESCAPE, CH_P,     1'b0, 1'b0, 8'h00},
    '{MODE_KEEP_ESCAPE, BYTE_ESC, 1'b0, 1'b0, 8'h00},
    '{MODE_KEEP_ESCAPE, CH_X,     1'b0, 1'b0, 8'h00},
    '{MODE_KEEP_ESCAPE, BYTE_ESC, 1'b0, 1'b0, 8'h00},
    '{MODE_KEEP_ESCAPE, 8'h7F,    1'b0, 1'b0, 8'h00}
  };

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [7:0]            in_tdata;    // [7:0] data_byte
  logic                  out_tvalid;
  logic                  out_tready;
  logic [7:0]            out_tdata;   // [7:0] out_byte
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  logic [7:0]   kept_bytes_q [$];
  logic [7:0]   want_byte;
  logic         mode_q;
  parse_state_t parser_q;
  bit           steady;
  int unsigned  fail_count;
  int unsigned  random_sent;

  ansi_escape_filter_unit uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic parse_state_t parse_next(parse_state_t st, logic [7:0] b);
    case (st)
      PS_IDLE: begin
        return (b == BYTE_ESC) ? PS_ESC : PS_IDLE;
      end
      PS_ESC: begin
        if (b == CH_X) return PS_STR;
        if (b == CH_P || b == CH_RBR || b == CH_CARET || b == CH_USC) return PS_LSTR;
        if (b == CH_LBR) return PS_CSI;
        return PS_IDLE;
      end
      PS_LSTR: begin
        if (b == BYTE_ESC) return PS_ESC_STR;
        if (b < 8'h08 || (b > 8'h0D && b < 8'h20) || b > 8'h7E) return PS_IDLE;
        return PS_LSTR;
      end
      PS_ESC_STR: begin
        return (b == CH_X || b == CH_BSL) ? PS_IDLE : PS_ESC_STR;
      end
      PS_STR: begin
        return (b == BYTE_ESC) ? PS_ESC_STR : PS_STR;
      end
      PS_CSI: begin
        if (b >= 8'h40 && b <= 8'h7E) return PS_IDLE;
        if (b >= 8'h20 && b <= 8'h2F) return PS_INTER;
        if (b >= 8'h30 && b <= 8'h3F) return PS_CSI;
        return PS_IDLE;
      end
      default: begin
        return PS_IDLE;
      end
    endcase
  endfunction

  function automatic logic byte_kept(logic mode, parse_state_t st, logic [7:0] b);
    if (mode == MODE_KEEP_TEXT) return (st == PS_IDLE) && (b != BYTE_ESC);
    return (st != PS_IDLE) || (b == BYTE_ESC);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic fixed, input logic kept,
                           input logic [7:0] kept_b);
    while (!steady && $urandom_range(0, 99) < 31) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    if (fixed) begin
      if (kept) kept_bytes_q.push_back(kept_b);
    end else if (byte_kept(mode_q, parser_q, b)) begin
      kept_bytes_q.push_back(b);
    end
    parser_q = parse_next(parser_q, b);
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (kept_bytes_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_mode(input logic m);
    logic [CFG_DATA_W-1:0] val;
    val    = $urandom();
    val[0] = m;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= REG_FILTER_MODE;
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    mode_q = m;
  endtask

  function automatic logic [7:0] abort_byte();
    logic [7:0] b;
    case ($urandom_range(0, 2))
      0: b = 8'($urandom_range(8'h00, 8'h07));
      1: begin
        b = 8'($urandom_range(8'h0E, 8'h1F));
        if (b == BYTE_ESC) b = 8'h1F;
      end
      default: b = 8'($urandom_range(8'h7F, 8'hFF));
    endcase
    return b;
  endfunction

  task automatic send_burst();
    logic [7:0]  seq [$];
    int unsigned n;
    n = 0;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        n = $urandom_range(1, 8);
        repeat (n) begin
          if ($urandom_range(0, 3) == 0) seq.push_back(8'($urandom_range(0, 255)));
          else seq.push_back(8'($urandom_range(8'h20, 8'h7E)));
        end
      end
      3, 4: begin
        seq.push_back(BYTE_ESC);
        seq.push_back(CH_LBR);
        n = $urandom_range(0, 4);
        repeat (n) seq.push_back(8'($urandom_range(8'h30, 8'h3F)));
        if ($urandom_range(0, 2) == 0) seq.push_back(8'($urandom_range(8'h20, 8'h2F)));
        if ($urandom_range(0, 4) == 0) seq.push_back(8'($urandom_range(0, 255)));
        else seq.push_back(8'($urandom_range(8'h40, 8'h7E)));
      end
      5: begin
        seq.push_back(BYTE_ESC);
        seq.push_back(CH_X);
        n = $urandom_range(0, 8);
        repeat (n) seq.push_back(8'($urandom_range(0, 255)));
        seq.push_back(BYTE_ESC);
        seq.push_back($urandom_range(0, 1) ? CH_X : CH_BSL);
      end
      6, 7: begin
        seq.push_back(BYTE_ESC);
        case ($urandom_range(0, 3))
          0: seq.push_back(CH_P);
          1: seq.push_back(CH_RBR);
          2: seq.push_back(CH_CARET);
          default: seq.push_back(CH_USC);
        endcase
        n = $urandom_range(0, 8);
        repeat (n) begin
          if ($urandom_range(0, 3) == 0) seq.push_back(8'($urandom_range(8'h08, 8'h0D)));
          else seq.push_back(8'($urandom_range(8'h20, 8'h7E)));
        end
        if ($urandom_range(0, 1)) begin
          seq.push_back(BYTE_ESC);
          seq.push_back(CH_BSL);
        end else begin
          seq.push_back(abort_byte());
        end
      end
      8: begin
        seq.push_back(BYTE_ESC);
        seq.push_back(8'($urandom_range(0, 255)));
      end
      default: begin
        seq.push_back(8'($urandom_range(0, 255)));
      end
    endcase
    foreach (seq[i]) send_byte(seq[i], 1'b0, 1'b0, 8'h00);
    random_sent += seq.size();
  endtask

  always @(posedge clk) begin
    out_tready <= steady || ($urandom_range(0, 99) >= 31);
    if (rst_n && out_tvalid && out_tready) begin
      if (kept_bytes_q.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("unexpected item: out_byte %02h", out_tdata);
      end else begin
        want_byte = kept_bytes_q.pop_front();
        if (out_tdata !== want_byte) begin
          fail_count++;
          if (fail_count <= 10)
            $display("out_byte mismatch: expected %02h, got %02h", want_byte, out_tdata);
        end
      end
    end
  end

  initial begin
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= 8'h00;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    mode_q      = MODE_KEEP_TEXT;
    parser_q    = PS_IDLE;
    steady      = 1'b0;
    fail_count  = 0;
    random_sent = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < ROW_COUNT; i++) begin
      if (DIRECTED_ROWS[i].mode != mode_q) begin
        settle();
        write_mode(DIRECTED_ROWS[i].mode);
      end
      send_byte(DIRECTED_ROWS[i].data, DIRECTED_ROWS[i].fixed, DIRECTED_ROWS[i].kept,
                DIRECTED_ROWS[i].kept_byte);
    end

    for (int p = 0; p < 6; p++) begin
      settle();
      write_mode((p % 2 == 0) ? MODE_KEEP_TEXT : MODE_KEEP_ESCAPE);
      steady = (p == 2);
      while (random_sent < (p + 1) * 100) send_burst();
    end
    steady = 1'b0;

    settle();
    if (kept_bytes_q.size() != 0) fail_count++;
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
